// ===== hw/rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgW    = 32;

  localparam logic [RegIdxW-1:0] RegAc1    = 3'd0;
  localparam logic [RegIdxW-1:0] RegAc2    = 3'd1;
  localparam logic [RegIdxW-1:0] RegAc3    = 3'd2;
  localparam logic [RegIdxW-1:0] RegAc4    = 3'd3;
  localparam logic [RegIdxW-1:0] RegAc5Ac6 = 3'd4;
  localparam logic [RegIdxW-1:0] RegB1B2   = 3'd5;
  localparam logic [RegIdxW-1:0] RegMcMd   = 3'd6;
  localparam logic [RegIdxW-1:0] RegOss    = 3'd7;

  localparam logic [31:0] MgCoef = 32'd3038;
  localparam logic [31:0] MhCoef = 32'hFFFFE343;
  localparam logic [31:0] MiCoef = 32'd3791;

  // sequencer steps, each one multiply, one add/shift step, a divider wait or a handshake
  typedef enum logic [4:0] {
    StIdle,
    StT0, StT1, StTDiv, StTDone,
    StP0, StP1, StP2, StP3, StP4, StP5, StP6, StP7, StP8, StP9, StPDiv,
    StPQ, StP10, StP11, StP12, StP13,
    StOut
  } state_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

// ===== hw/rtl/bsc_divider.sv =====
module bsc_divider import bsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // unsigned restoring divider, one quotient bit per cycle
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without run");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !done_q && cnt_q != 6'd0 |-> !(busy_q && cnt_q > 6'd32))
    else $error("divider count overrun");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while running");

endmodule

// ===== hw/rtl/baro_sensor_compensation_core.sv =====
// barometric compensation core
// slave stream: tuser = command (0 temperature, 1 pressure), tdata = raw reading.
// master stream: tuser = {invalid, result_kind}, tdata = signed value.
// calibration registers are written over a plain write port (index 0..7);
// write only while the core is idle.
// one shared 32x32 multiplier does one product per cycle under the
// sequencer, and a serial divider handles the single division, producing
// 32 quotient bits and then a done strobe.
// a zero divisor skips the divider, and the result goes straight to the output step.
// s_axis_tready is high only in the idle step, so one beat is in work at a
// time. the result stays on the master side until taken; a stalled receiver
// holds the core in its output step and no new beat is accepted.
// reset clears the calibration registers, the stored b5 and the sequencer.
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // raw_reading[18:0], zero fill
  input  logic               s_axis_tuser,   // command
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // value
  output logic [1:0]         m_axis_tuser    // {invalid, result_kind}
);

  logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
  logic [31:0] ac56_q, b12_q, mcmd_q, b5_q, b5_d;
  logic [1:0]  oss_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac1_q <= '0; ac2_q <= '0; ac3_q <= '0; ac4_q <= '0;
      ac56_q <= '0; b12_q <= '0; mcmd_q <= '0; oss_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAc1:    ac1_q  <= cfg_data_i[15:0];
        RegAc2:    ac2_q  <= cfg_data_i[15:0];
        RegAc3:    ac3_q  <= cfg_data_i[15:0];
        RegAc4:    ac4_q  <= cfg_data_i[15:0];
        RegAc5Ac6: ac56_q <= cfg_data_i;
        RegB1B2:   b12_q  <= cfg_data_i;
        RegMcMd:   mcmd_q <= cfg_data_i;
        RegOss:    oss_q  <= cfg_data_i[1:0];
        default:   ;
      endcase
    end
  end

  state_e st_q, st_d;
  logic [31:0] raw_q, raw_d, a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d;
  logic [31:0] x_q, x_d, val_q, val_d;
  logic        kind_q, kind_d, inv_q, inv_d, neg_q, neg_d, big_q, big_d;
  logic [31:0] ma, mb, prod;
  div_req_t    dreq;
  div_rsp_t    drsp;

  bsc_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // shared multiplier: one 32x32 low product a cycle
  assign prod = ma * mb;

  logic [31:0] b6;
  assign b6 = b5_q - 32'd4000;

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle:  if (s_axis_tvalid) st_d = s_axis_tuser ? StP0 : StT0;
      StT0:    st_d = StT1;
      StT1:    st_d = (a_q + sx16(mcmd_q[15:0]) == 32'd0) ? StOut : StTDiv;
      StTDiv:  if (drsp.done) st_d = StTDone;
      StTDone: st_d = StOut;
      StP0:    st_d = StP1;
      StP1:    st_d = StP2;
      StP2:    st_d = StP3;
      StP3:    st_d = StP4;
      StP4:    st_d = StP5;
      StP5:    st_d = StP6;
      StP6:    st_d = StP7;
      StP7:    st_d = StP8;
      StP8:    st_d = StP9;
      StP9:    st_d = (c_q == 32'd0) ? StOut : StPDiv;
      StPDiv:  if (drsp.done) st_d = StPQ;
      StPQ:    st_d = StP10;
      StP10:   st_d = StP11;
      StP11:   st_d = StP12;
      StP12:   st_d = StP13;
      StP13:   st_d = StOut;
      StOut:   if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // datapath per step
  always_comb begin
    raw_d = raw_q; a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; x_d = x_q;
    val_d = val_q; kind_d = kind_q; inv_d = inv_q; neg_d = neg_q; big_d = big_q;
    b5_d = b5_q;
    ma = 32'd0; mb = 32'd0;
    dreq = '0;
    case (st_q)
      StIdle: begin
        raw_d = {13'd0, s_axis_tdata[18:0]};
        kind_d = s_axis_tuser;
        inv_d = 1'b0;
        val_d = 32'd0;
      end
      // x1 = (ut - ac6) * ac5 >>> 15
      StT0: begin
        ma = raw_q - {16'd0, ac56_q[15:0]};
        mb = {16'd0, ac56_q[31:16]};
        a_d = $signed(prod) >>> 15;
      end
      StT1: begin
        b_d = a_q + sx16(mcmd_q[15:0]);
        c_d = sx16(mcmd_q[31:16]) << 11;
        neg_d = c_d[31] ^ b_d[31];
        if (b_d == 32'd0) inv_d = 1'b1;
        else begin
          dreq.start = 1'b1;
          dreq.num = c_d[31] ? 32'd0 - c_d : c_d;
          dreq.den = b_d[31] ? 32'd0 - b_d : b_d;
        end
      end
      StTDone: begin
        b5_d = a_q + (neg_q ? 32'd0 - drsp.quo : drsp.quo);
        x_d = b5_d + 32'd8;
        val_d = sx16(16'(($signed(x_d)) >>> 4));
      end
      // sq = b6*b6 >>> 12
      StP0: begin
        ma = b6; mb = b6;
        a_d = $signed(prod) >>> 12;
      end
      // x1 = sq*b2 >>> 11
      StP1: begin
        ma = a_q; mb = sx16(b12_q[15:0]);
        b_d = $signed(prod) >>> 11;
      end
      // x2 = ac2*b6 >>> 11, b3
      StP2: begin
        ma = sx16(ac2_q); mb = b6;
        x_d = (((sx16(ac1_q) << 2) + b_q + $unsigned($signed(prod) >>> 11)) << oss_q)
              + 32'd2;
        d_d = $signed(x_d) >>> 2;
      end
      // x1 = ac3*b6 >>> 13
      StP3: begin
        ma = sx16(ac3_q); mb = b6;
        b_d = $signed(prod) >>> 13;
      end
      // x2 = b1*sq >>> 16
      StP4: begin
        ma = sx16(b12_q[31:16]); mb = a_q;
        x_d = b_q + $unsigned($signed(prod) >>> 16) + 32'd2;
        b_d = $unsigned($signed(x_d) >>> 2) + 32'd32768;
      end
      // b4
      StP5: begin
        ma = {16'd0, ac4_q}; mb = b_q;
        c_d = prod >> 15;
      end
      // b7
      StP6: begin
        ma = raw_q - d_q; mb = 32'd50000 >> oss_q;
        b_d = prod;
      end
      StP7: begin
        big_d = b_q[31];
      end
      StP8: ;
      StP9: begin
        if (c_q == 32'd0) inv_d = 1'b1;
        else begin
          dreq.start = 1'b1;
          dreq.num = big_q ? b_q : b_q << 1;
          dreq.den = c_q;
        end
      end
      StPQ: begin
        x_d = big_q ? drsp.quo << 1 : drsp.quo;
        a_d = $signed(x_d) >>> 8;
      end
      // x1 = (p>>>8)^2
      StP10: begin
        ma = a_q; mb = a_q;
        a_d = prod;
      end
      StP11: begin
        ma = a_q; mb = MgCoef;
        a_d = $signed(prod) >>> 16;
      end
      StP12: begin
        ma = x_q; mb = MhCoef;
        b_d = $signed(prod) >>> 16;
      end
      StP13: begin
        d_d = a_q + b_q + MiCoef;
        val_d = x_q + $unsigned($signed(d_d) >>> 4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      b5_q <= '0;
    end else begin
      st_q <= st_d;
      b5_q <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d; a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d;
    x_q <= x_d; val_q <= val_d; kind_q <= kind_d; inv_q <= inv_d;
    neg_q <= neg_d; big_q <= big_d;
  end

  // outputs
  always_comb begin
    s_axis_tready = (st_q == StIdle);
    m_axis_tvalid = (st_q == StOut);
    m_axis_tdata  = val_q;
    m_axis_tuser  = {inv_q, kind_q};
  end

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && inv_q |-> val_q == 32'd0) else $error("invalid with value");
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("both sides open");
  a_b5_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b5_q != $past(b5_q) |-> $past(st_q) == StTDone) else $error("b5 changed");

endmodule

// ===== test/testbench.sv =====
module testbench;
  import bsc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  localparam logic CmdTemp  = 1'b0;
  localparam logic CmdPress = 1'b1;
  localparam int   WatchdogLimit = 4000;

  typedef struct packed {
    logic        cmd;
    logic [18:0] raw;
  } reading_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        invalid;
  } comp_t;

  baro_sensor_compensation_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model copy of the calibration registers and the stored b5
  logic [31:0] m_ac1, m_ac2, m_ac3, m_ac4, m_ac56, m_b12, m_mcmd, m_b5;
  logic [1:0]  m_oss;

  reading_t pending_q[$];
  comp_t    expected_q[$];
  int       errors = 0;
  int       n_temp = 0, n_press = 0, n_inv = 0, n_results = 0;
  bit       stim_done = 1'b0;

  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sdiv32(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // compensation arithmetic, 32-bit wrap throughout
  function automatic comp_t compensate(reading_t r);
    comp_t c;
    logic [31:0] ut, ac5, ac6, mc, md, x1, x2, x3, den, b6, sq, b3, b4, b7, p;
    c.kind = r.cmd;
    c.value = '0;
    c.invalid = 1'b0;
    ut = {13'd0, r.raw};
    if (r.cmd == CmdTemp) begin
      ac5 = {16'd0, m_ac56[31:16]};
      ac6 = {16'd0, m_ac56[15:0]};
      mc = {{16{m_mcmd[31]}}, m_mcmd[31:16]};
      md = {{16{m_mcmd[15]}}, m_mcmd[15:0]};
      x1 = asr32((ut - ac6) * ac5, 15);
      den = x1 + md;
      if (den == 0) begin
        c.invalid = 1'b1;
      end else begin
        m_b5 = x1 + sdiv32(mc << 11, den);
        x2 = asr32(m_b5 + 32'd8, 4);
        c.value = {{16{x2[15]}}, x2[15:0]};
      end
    end else begin
      b6 = m_b5 - 32'd4000;
      sq = asr32(b6 * b6, 12);
      x1 = asr32(sq * {{16{m_b12[15]}}, m_b12[15:0]}, 11);
      x2 = asr32(m_ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = asr32(((m_ac1 * 32'd4 + x3) << m_oss) + 32'd2, 2);
      x1 = asr32(m_ac3 * b6, 13);
      x2 = asr32({{16{m_b12[31]}}, m_b12[31:16]} * sq, 16);
      x3 = asr32(x1 + x2 + 32'd2, 2);
      b4 = (m_ac4 * (x3 + 32'd32768)) >> 15;
      b7 = (ut - b3) * (32'd50000 >> m_oss);
      if (b4 == 0) begin
        c.invalid = 1'b1;
      end else begin
        p = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
        x1 = asr32(p, 8);
        x1 = x1 * x1;
        x1 = asr32(x1 * MgCoef, 16);
        x2 = asr32(p * MhCoef, 16);
        p = p + asr32(x1 + x2 + MiCoef, 4);
        c.value = p;
      end
    end
    return c;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_q.push_back(compensate(pending_q.pop_front()));
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap_left > 0 || pending_q.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        // next beat is the head of the queue, the accepted one is already gone
        reading_t nx;
        nx = pending_q[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, nx.raw};
        s_axis_tuser <= nx.cmd;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(8, 0);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
        end
      end
    end
  end

  // receiver stall pattern and result check
  int stall_phase = 0;
  always @(posedge clk_i) begin
    comp_t exp_c;
    stall_phase <= stall_phase + 1;
    m_axis_tready <= (stall_phase[8:6] == 3'd0) ? 1'b1 : ($urandom_range(3, 0) != 0);
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%h inv=%0d", $time,
                 m_axis_tuser[0], m_axis_tdata, m_axis_tuser[1]);
        errors++;
      end else begin
        exp_c = expected_q.pop_front();
        if (exp_c.kind != m_axis_tuser[0]) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_c.kind, m_axis_tuser[0]);
          errors++;
        end
        if (exp_c.value != m_axis_tdata) begin
          $display("%0t: value expected %h actual %h", $time, exp_c.value, m_axis_tdata);
          errors++;
        end
        if (exp_c.invalid != m_axis_tuser[1]) begin
          $display("%0t: invalid expected %0d actual %0d", $time, exp_c.invalid,
                   m_axis_tuser[1]);
          errors++;
        end
        if (exp_c.invalid) n_inv++;
        if (exp_c.kind == CmdPress) n_press++; else n_temp++;
      end
    end
  end

  // watchdog on cycles with no beat in either direction
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      RegAc1:    m_ac1 = {{16{data[15]}}, data[15:0]};
      RegAc2:    m_ac2 = {{16{data[15]}}, data[15:0]};
      RegAc3:    m_ac3 = {{16{data[15]}}, data[15:0]};
      RegAc4:    m_ac4 = {16'd0, data[15:0]};
      RegAc5Ac6: m_ac56 = data;
      RegB1B2:   m_b12 = data;
      RegMcMd:   m_mcmd = data;
      RegOss:    m_oss = data[1:0];
      default:   ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // typical datasheet-like calibration set
  task automatic load_typical(logic [1:0] oss);
    write_reg(RegAc1, 32'd408);
    write_reg(RegAc2, -32'sd72);
    write_reg(RegAc3, -32'sd14383);
    write_reg(RegAc4, 32'd32741);
    write_reg(RegAc5Ac6, {16'd32757, 16'd23153});
    write_reg(RegB1B2, {16'd6190, 16'd4});
    write_reg(RegMcMd, {-16'sd8711, 16'd2868});
    write_reg(RegOss, {30'd0, oss});
  endtask

  task automatic push(logic cmd, logic [18:0] raw);
    reading_t r;
    r.cmd = cmd;
    r.raw = raw;
    pending_q.push_back(r);
  endtask

  // mostly temperature then pressure pairs in the sensor range
  task automatic push_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9, 0))
        0: push(1'($urandom_range(1, 0)), 19'($urandom));
        1: push(CmdPress, 19'($urandom));
        default: begin
          push(CmdTemp, 19'($urandom_range(32000, 20000)));
          push(CmdPress, 19'($urandom_range(120000, 20000) << $urandom_range(2, 0)));
          i++;
        end
      endcase
    end
  endtask

  initial begin
    m_ac1 = '0; m_ac2 = '0; m_ac3 = '0; m_ac4 = '0;
    m_ac56 = '0; m_b12 = '0; m_mcmd = '0; m_b5 = '0; m_oss = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero registers: both divisors zero, pressure before any temperature
    push(CmdPress, 19'd0);
    push(CmdTemp, 19'd0);
    push(CmdPress, 19'h7FFFF);
    wait_drained();

    // directed pass on typical coefficients
    load_typical(2'd0);
    push(CmdTemp, 19'd27898);
    push(CmdPress, 19'd23843);
    push(CmdTemp, 19'd0);
    push(CmdTemp, 19'hFFFF);
    push(CmdTemp, 19'h7FFFF);
    push(CmdPress, 19'd0);
    push(CmdPress, 19'h7FFFF);
    push(CmdPress, 19'h55555);
    push(CmdPress, 19'h2AAAA);
    wait_drained();

    // zero temperature divisor: mc only, md cancels x1 (ac5 = 0 gives x1 = 0)
    write_reg(RegAc5Ac6, 32'h0000_0000);
    write_reg(RegMcMd, 32'h7FFF_0000);
    push(CmdTemp, 19'd12345);
    push(CmdPress, 19'd40000);
    wait_drained();

    // coefficient extremes
    write_reg(RegAc1, 32'h8000);
    write_reg(RegAc2, 32'h7FFF);
    write_reg(RegAc3, 32'h8000);
    write_reg(RegAc4, 32'hFFFF);
    write_reg(RegAc5Ac6, 32'hFFFF_FFFF);
    write_reg(RegB1B2, 32'h8000_7FFF);
    write_reg(RegMcMd, 32'h8000_8000);
    write_reg(RegOss, 32'd3);
    push(CmdTemp, 19'h7FFFF);
    push(CmdPress, 19'h7FFFF);
    push(CmdTemp, 19'd0);
    push(CmdPress, 19'd1);
    wait_drained();

    // random phases across oversampling settings and random coefficients
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        load_typical(ph[1:0]);
      end else begin
        for (int k = 0; k < NumRegs; k++) write_reg(k[2:0], $urandom);
      end
      push_random(128);
      wait_drained();
    end

    stim_done = 1'b1;
    $display("checked %0d results: %0d temperature, %0d pressure, %0d invalid",
             n_results, n_temp, n_press, n_inv);
    $display("covered zero divisors, coefficient extremes and all oversampling modes");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
